/* rtl/core/dnsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dnsp_pkg: shared types and constants for the DNS TCP message parser
// Parse phases, record kinds and the result record layout.
// ----------------------------------------------------------------------------
package dnsp_pkg;

  localparam int unsigned POS_W = 17;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  localparam logic [POS_W-1:0] HDR_WORDS_END = POS_W'(8);
  localparam logic [POS_W-1:0] HDR_LAST_POS  = POS_W'(11);
  localparam logic [POS_W-1:0] TTL_OFF_FIRST = POS_W'(6);
  localparam logic [POS_W-1:0] TTL_OFF_LAST  = POS_W'(9);
  localparam logic [7:0]       QFIX_BYTES    = 8'd4;

  localparam logic [1:0] HW_ID    = 2'd0;
  localparam logic [1:0] HW_FLAGS = 2'd1;
  localparam logic [1:0] HW_QDCNT = 2'd2;
  localparam logic [1:0] HW_ANCNT = 2'd3;

  typedef enum logic [2:0] {
    PH_LEN        = 3'd0,
    PH_HDR        = 3'd1,
    PH_NAME_FIRST = 3'd2,
    PH_NAME       = 3'd3,
    PH_QFIX       = 3'd4,
    PH_TAIL       = 3'd5,
    PH_BAD        = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] msg_id;
    logic        is_response;
    logic [3:0]  opcode;
    logic [6:0]  flag_bits;
    logic [3:0]  rcode;
    logic [15:0] answer_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [31:0] answer_ttl;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/dns_tcp_message_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dns_tcp_message_parser: byte-serial DNS-over-TCP message parser
// Unpacks header, question name, QTYPE/QCLASS and first answer TTL, and
// emits name characters plus one summary or malformed record per message.
// ----------------------------------------------------------------------------
//  channel | signals                         | beat
//  input   | in_valid, in_stall, data_byte   | one stream byte
//  output  | out_valid, out_stall, kind..last| one record (char/summary/bad)
//
// The parser takes one byte per cycle while in_stall is low; each record is
// registered in the output register, or in the skid entry on a stall.
// Synchronous reset returns the parser to the length prefix phase.
// A two-entry output (output register plus skid) absorbs one stalled record;
// in_stall rises only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module dns_tcp_message_parser
  import dnsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       name_char,
  output logic [15:0]      msg_id,
  output logic             is_response,
  output logic [3:0]       opcode,
  output logic [6:0]       flag_bits,
  output logic [3:0]       rcode,
  output logic [15:0]      answer_count,
  output logic [15:0]      query_type,
  output logic [15:0]      query_class,
  output logic [31:0]      answer_ttl,
  output logic             last
);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] frame_length, frame_length_next;
  logic [7:0]       label_bytes_left, label_bytes_left_next;
  logic [15:0]      header_words [4];
  logic [15:0]      header_words_next [4];
  logic [POS_W-1:0] question_end, question_end_next;
  logic [31:0]      type_and_class, type_and_class_next;
  logic [31:0]      ttl_shift, ttl_shift_next;

  result_t          res;
  logic             res_valid;
  result_t          out_rec, skid_rec;
  logic             skid_valid;
  logic             accept;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] tail_off;
  logic             msg_last;
  logic             has_char;
  logic [7:0]       ch;
  logic             do_bad;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign pos_inc  = byte_position + POS_W'(1);
  assign tail_off = byte_position - question_end;

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    frame_length_next     = frame_length;
    label_bytes_left_next = label_bytes_left;
    header_words_next     = header_words;
    question_end_next     = question_end;
    type_and_class_next   = type_and_class;
    ttl_shift_next        = ttl_shift;
    msg_last              = 1'b0;
    has_char              = 1'b0;
    ch                    = 8'd0;
    do_bad                = 1'b0;

    if (phase == PH_LEN) begin
      if (byte_position == '0) begin
        frame_length_next  = {{(POS_W-8){1'b0}}, data_byte};
        byte_position_next = POS_W'(1);
      end else begin
        frame_length_next     = {{(POS_W-16){1'b0}}, frame_length[7:0], data_byte};
        byte_position_next    = '0;
        header_words_next     = '{default: 16'd0};
        label_bytes_left_next = 8'd0;
        question_end_next     = '0;
        type_and_class_next   = 32'd0;
        ttl_shift_next        = 32'd0;
        if (frame_length[7:0] == 8'd0 && data_byte == 8'd0) begin
          do_bad = 1'b1;
        end else begin
          phase_next = PH_HDR;
        end
      end
    end else begin
      msg_last = (pos_inc == frame_length);
      unique case (phase)
        PH_HDR: begin
          if (byte_position < HDR_WORDS_END) begin
            header_words_next[byte_position[2:1]] =
              {header_words[byte_position[2:1]][7:0], data_byte};
          end
          if (byte_position == HDR_LAST_POS) begin
            phase_next = (header_words[HW_QDCNT] == 16'd0) ? PH_BAD : PH_NAME_FIRST;
          end
        end
        PH_NAME_FIRST: begin
          if (data_byte == 8'd0) begin
            label_bytes_left_next = QFIX_BYTES;
            phase_next            = PH_QFIX;
          end else begin
            label_bytes_left_next = data_byte;
            phase_next            = PH_NAME;
          end
        end
        PH_NAME: begin
          if (label_bytes_left != 8'd0) begin
            has_char              = 1'b1;
            ch                    = data_byte;
            label_bytes_left_next = label_bytes_left - 8'd1;
          end else if (data_byte == 8'd0) begin
            label_bytes_left_next = QFIX_BYTES;
            phase_next            = PH_QFIX;
          end else begin
            has_char              = 1'b1;
            ch                    = DOT_CHAR;
            label_bytes_left_next = data_byte;
          end
        end
        PH_QFIX: begin
          type_and_class_next = {type_and_class[23:0], data_byte};
          if (label_bytes_left != 8'd0) begin
            label_bytes_left_next = label_bytes_left - 8'd1;
          end
          if (label_bytes_left_next == 8'd0) begin
            question_end_next = pos_inc;
            phase_next        = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (header_words[HW_ANCNT] != 16'd0 && byte_position >= question_end &&
              tail_off >= TTL_OFF_FIRST && tail_off <= TTL_OFF_LAST) begin
            ttl_shift_next = {ttl_shift[23:0], data_byte};
          end
        end
        default: begin
          phase_next = PH_BAD;
        end
      endcase
      byte_position_next = pos_inc;
      if (msg_last) begin
        phase_next         = PH_LEN;
        byte_position_next = '0;
        frame_length_next  = '0;
      end
    end
  end

  // build the record from the post-update message state
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (do_bad || (msg_last && phase_next == PH_LEN && phase != PH_LEN)) begin
      res_valid = 1'b1;
      res.last  = 1'b1;
      if (!do_bad && (phase == PH_TAIL || (phase == PH_QFIX &&
          label_bytes_left_next == 8'd0))) begin
        res.kind         = KIND_SUMMARY;
        res.msg_id       = header_words_next[HW_ID];
        res.is_response  = header_words_next[HW_FLAGS][15];
        res.opcode       = header_words_next[HW_FLAGS][14:11];
        res.flag_bits    = header_words_next[HW_FLAGS][10:4];
        res.rcode        = header_words_next[HW_FLAGS][3:0];
        res.answer_count = header_words_next[HW_ANCNT];
        res.query_type   = type_and_class_next[31:16];
        res.query_class  = type_and_class_next[15:0];
        res.answer_ttl   = (header_words_next[HW_ANCNT] != 16'd0) ? ttl_shift_next : 32'd0;
      end else begin
        res.kind = KIND_BAD;
      end
    end else if (has_char) begin
      res_valid     = 1'b1;
      res.kind      = KIND_CHAR;
      res.name_char = ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEN;
      byte_position    <= '0;
      frame_length     <= '0;
      label_bytes_left <= 8'd0;
      header_words     <= '{default: 16'd0};
      question_end     <= '0;
      type_and_class   <= 32'd0;
      ttl_shift        <= 32'd0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      frame_length     <= frame_length_next;
      label_bytes_left <= label_bytes_left_next;
      header_words     <= header_words_next;
      question_end     <= question_end_next;
      type_and_class   <= type_and_class_next;
      ttl_shift        <= ttl_shift_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept && res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= accept && res_valid;
    end else begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept && res_valid) begin
        skid_rec <= res;
      end
    end else if (skid_valid) begin
      out_rec <= skid_rec;
      if (accept && res_valid) begin
        skid_rec <= res;
      end
    end else if (accept && res_valid) begin
      out_rec <= res;
    end
  end

  assign kind         = out_rec.kind;
  assign name_char    = out_rec.name_char;
  assign msg_id       = out_rec.msg_id;
  assign is_response  = out_rec.is_response;
  assign opcode       = out_rec.opcode;
  assign flag_bits    = out_rec.flag_bits;
  assign rcode        = out_rec.rcode;
  assign answer_count = out_rec.answer_count;
  assign query_type   = out_rec.query_type;
  assign query_class  = out_rec.query_class;
  assign answer_ttl   = out_rec.answer_ttl;
  assign last         = out_rec.last;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied with empty output register");

  a_char_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_CHAR) |-> !last)
    else $error("name character record marked last");

  a_len_phase_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEN) |-> (byte_position <= POS_W'(1)))
    else $error("length prefix phase with stray byte position");
`endif

endmodule
`default_nettype wire
